// File: hw/rtl/ufmt_pkg.sv
// Shared types, constants and helpers for the unsigned-to-ASCII formatter.
// Used by ufmt_conv, ufmt_emit and unsigned_to_ascii_formatter_top.
package ufmt_pkg;

    // Fixed field widths of the item channels
    localparam int VALUE_FIELD_W = 32;
    localparam int CHAR_W        = 8;

    // Default for the value width parameter
    localparam int VALUE_WIDTH_DEF = 32;

    // Character constants
    localparam logic [CHAR_W-1:0] ASCII_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_X        = 8'h78;
    localparam logic [CHAR_W-1:0] HEX_LETTER_GAP = 8'd39;
    localparam logic [3:0]        DIGIT_TEN      = 4'd10;
    localparam logic [3:0]        DIGIT_FIVE     = 4'd5;
    localparam logic [3:0]        DIGIT_ADJ      = 4'd3;

    // Format selector codes
    localparam logic FUNC_DEC = 1'b0;
    localparam logic FUNC_HEX = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [VALUE_FIELD_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } out_item_t;

    // Converter to emitter handoff
    typedef struct packed {
        logic done;
        logic hex;
    } conv_ctl_t;

    // Shift-and-add-3 correction of one BCD digit
    function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= DIGIT_FIVE) ? d + DIGIT_ADJ : d;
        return r;
    endfunction

    // ASCII code of one digit, decimal or lower-case hex
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        c = ASCII_ZERO + {4'd0, d};
        if (d >= DIGIT_TEN)
        begin
            c = c + HEX_LETTER_GAP;
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/ufmt_conv.sv
// Bit-serial value to digit converter: double dabble for decimal, direct load for hex.
// Depends on ufmt_pkg.
module ufmt_conv #(
    parameter int UW  = ufmt_pkg::VALUE_WIDTH_DEF,
    parameter int NIB = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  ufmt_pkg::in_item_t            item,
    output ufmt_pkg::conv_ctl_t           ctl,
    output logic [4*NIB-1:0]              digits
);

    localparam int CW = $clog2(UW + 1);
    localparam int DW = 4 * NIB;

    logic [UW-1:0] val_reg, val_next;
    logic [DW-1:0] dig_reg, dig_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic          hex_reg, hex_next;
    logic [DW-1:0] dig_adj;

    // Correct every BCD digit before the shift
    always_comb
    begin
        for (int n = 0; n < NIB; n++)
        begin
            dig_adj[4*n +: 4] = ufmt_pkg::bcd_adjust(dig_reg[4*n +: 4]);
        end
    end

    // Load, then shift one value bit per cycle into the digit register
    always_comb
    begin
        val_next  = val_reg;
        dig_next  = dig_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        hex_next  = hex_reg;
        done_next = 1'b0;
        if (start)
        begin
            hex_next = item.func;
            val_next = item.value[UW-1:0];
            if (item.func == ufmt_pkg::FUNC_HEX)
            begin
                dig_next  = DW'(item.value[UW-1:0]);
                done_next = 1'b1;
            end
            else
            begin
                dig_next = '0;
                cnt_next = CW'(UW);
                run_next = 1'b1;
            end
        end
        else if (run_reg)
        begin
            dig_next = {dig_adj[DW-2:0], val_reg[UW-1]};
            val_next = {val_reg[UW-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            hex_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
            hex_reg  <= hex_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        dig_reg <= dig_next;
    end

    assign ctl.done = done_reg;
    assign ctl.hex  = hex_reg;
    assign digits   = dig_reg;

endmodule

// File: hw/rtl/ufmt_emit.sv
// Character emitter: prefix, leading-zero skip and one digit per cycle to the output item while not stalled.
// Depends on ufmt_pkg.
module ufmt_emit #(
    parameter int NIB = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ufmt_pkg::conv_ctl_t  ctl,
    input  logic [4*NIB-1:0]     digits,
    output logic                 fin,
    output logic                 valid,
    input  logic                 stall,
    output ufmt_pkg::out_item_t  item
);

    localparam int DW = 4 * NIB;
    localparam int IW = (NIB > 1) ? $clog2(NIB) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PFX0 = 2'd1;
    localparam logic [1:0] ST_PFXX = 2'd2;
    localparam logic [1:0] ST_DIG  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [DW-1:0]       dig_reg, dig_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                started_reg, started_next;
    logic                valid_reg, valid_next;
    ufmt_pkg::out_item_t item_reg, item_next;
    logic                slot_free;
    logic [3:0]          top_digit;

    assign slot_free = !valid_reg || !stall;
    assign top_digit = dig_reg[DW-1 -: 4];

    // Sequence prefix and digits into the output register
    always_comb
    begin
        state_next   = state_reg;
        dig_next     = dig_reg;
        idx_next     = idx_reg;
        started_next = started_reg;
        valid_next   = valid_reg && stall;
        item_next    = item_reg;
        fin          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.done)
                begin
                    dig_next     = digits;
                    idx_next     = IW'(NIB - 1);
                    started_next = 1'b0;
                    state_next   = ctl.hex ? ST_PFX0 : ST_DIG;
                end
            end
            ST_PFX0:
            begin
                if (slot_free)
                begin
                    valid_next          = 1'b1;
                    item_next.char_code = ufmt_pkg::ASCII_ZERO;
                    item_next.last      = 1'b0;
                    state_next          = ST_PFXX;
                end
            end
            ST_PFXX:
            begin
                if (slot_free)
                begin
                    valid_next          = 1'b1;
                    item_next.char_code = ufmt_pkg::ASCII_X;
                    item_next.last      = 1'b0;
                    state_next          = ST_DIG;
                end
            end
            ST_DIG:
            begin
                if (slot_free)
                begin
                    // Drop leading zeros, but always emit the final digit
                    if (started_reg || top_digit != 4'd0 || idx_reg == '0)
                    begin
                        valid_next          = 1'b1;
                        item_next.char_code = ufmt_pkg::digit_char(top_digit);
                        item_next.last      = (idx_reg == '0);
                        started_next        = 1'b1;
                    end
                    dig_next = {dig_reg[DW-5:0], 4'd0};
                    idx_next = idx_reg - IW'(1);
                    if (idx_reg == '0)
                    begin
                        fin        = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            started_reg <= started_next;
            valid_reg   <= valid_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        item_reg <= item_next;
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// File: hw/rtl/unsigned_to_ascii_formatter_top.sv
// Unsigned to ASCII formatter, top level.
// Depends on ufmt_pkg, ufmt_conv and ufmt_emit.
//
// Usage:
//   The source channel (src_valid, src_stall, src_item) takes one value and a
//   format selector; func 0 gives decimal, func 1 gives "0x" and lower-case hex.
//   The destination channel (dst_valid, dst_stall, dst_item) returns the text
//   one character per item, most significant first, with no leading zeros and
//   last set on the final character. Zero gives "0" or "0x0".
//   Only the low min(VALUE_WIDTH, 32) bits of value are used.
// Conversion:
//   Decimal: the double dabble converter shifts one value bit per cycle
//   into the digit register. The emitter then steps through every digit
//   position, leading zeros included, after the two prefix characters in
//   hex mode, and pauses while stalled. Hex skips the bit-serial shift and
//   loads its digits directly. One item is in work at a time.
// Reset and stall:
//   rst_n clears all control state; no item is pending afterwards.
//   A stalled receiver holds the output item and pauses the emitter; the
//   source stays stalled until the last character is loaded for output.
module unsigned_to_ascii_formatter_top #(
    parameter int VALUE_WIDTH = ufmt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  ufmt_pkg::in_item_t  src_item,
    output logic                dst_valid,
    input  logic                dst_stall,
    output ufmt_pkg::out_item_t dst_item
);

    localparam int UW      = (VALUE_WIDTH < ufmt_pkg::VALUE_FIELD_W) ?
                             VALUE_WIDTH : ufmt_pkg::VALUE_FIELD_W;
    localparam int DEC_NIB = ((UW * 1233) >> 12) + 1;
    localparam int HEX_NIB = (UW + 3) / 4;
    localparam int NIB     = (DEC_NIB > HEX_NIB) ? DEC_NIB : HEX_NIB;

    logic                busy_reg, busy_next;
    logic                accept;
    logic                fin;
    ufmt_pkg::conv_ctl_t ctl;
    logic [4*NIB-1:0]    digits;

    assign src_stall = busy_reg;
    assign accept    = src_valid && !busy_reg;

    // Hold busy from accept until the last character is loaded
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (fin)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    ufmt_conv #(
        .UW  (UW),
        .NIB (NIB)
    ) u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .item   (src_item),
        .ctl    (ctl),
        .digits (digits)
    );

    ufmt_emit #(
        .NIB (NIB)
    ) u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .digits (digits),
        .fin    (fin),
        .valid  (dst_valid),
        .stall  (dst_stall),
        .item   (dst_item)
    );

endmodule
